@@ hw/rtl/fdaxpy_pkg.sv @@
`default_nettype none

package fdaxpy_pkg;

  localparam int FracBits = 16;
  localparam int DataW    = 32;
  localparam int AccW     = 64;
  localparam int MulW     = DataW + 1;
  localparam int ProdW    = 2 * MulW;
  localparam int WideW    = AccW + DataW + 1;
  localparam int NumCols  = 4;
  localparam int ColIdxW  = 2;
  localparam int CfgIdxW  = 3;

  localparam logic [DataW-1:0] AlphaReset = DataW'(1) << FracBits;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ALPHA   = 3'd0,
    CFG_BETA    = 3'd1,
    CFG_X_ZERO  = 3'd2,
    CFG_X_ONE   = 3'd3,
    CFG_X_TWO   = 3'd4,
    CFG_X_THREE = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHI_MUL,
    ST_CHI_RND,
    ST_Z_MUL,
    ST_Z_ADD,
    ST_W_MUL,
    ST_W_ADD,
    ST_Z_RND,
    ST_Y_LO,
    ST_Y_HI,
    ST_Y_CMB,
    ST_Y_RND,
    ST_Y_MUL,
    ST_Y_ADD,
    ST_Y_FIN,
    ST_DONE
  } state_e;

  function automatic logic [AccW-1:0] sat_add64(input logic [AccW-1:0] x,
                                                input logic [AccW-1:0] y);
    logic [AccW:0] s;
    s = {x[AccW-1], x} + {y[AccW-1], y};
    if (s[AccW] != s[AccW-1]) begin
      return s[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end
    return s[AccW-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/fused_dot_axpy_four_column.sv @@
// Channel | Dir | Handshake              | Beat contents
// in      | in  | in_valid_i / in_stall_o | a_col0..3, w_elem, z_in, y_in0..3, last_row
// out     | out | out_valid_o/ out_stall_i| z_out, y_out0..3, y_valid
// cfg     | in  | cfg_valid_i/ cfg_ready_o| cfg_index_i, cfg_data_i
//
// One 33x33 multiplier and one rounder are shared under a sequencer; the 64-bit
// saturating adds use sat_add64. Each column steps through chi, z and w, then z
// is rounded; a last row then runs the y update per column before the result.
// The input stalls while a row is in work; the output register lets the next
// row be accepted while a result beat still waits. Reset is asynchronous and
// clears the sequencer, registers (alpha = 1.0) and the dot accumulators.
`default_nettype none

module fused_dot_axpy_four_column (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,

  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [fdaxpy_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [fdaxpy_pkg::DataW-1:0]         cfg_data_i,

  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic signed [fdaxpy_pkg::DataW-1:0]  a_col0_i,
  input  wire logic signed [fdaxpy_pkg::DataW-1:0]  a_col1_i,
  input  wire logic signed [fdaxpy_pkg::DataW-1:0]  a_col2_i,
  input  wire logic signed [fdaxpy_pkg::DataW-1:0]  a_col3_i,
  input  wire logic signed [fdaxpy_pkg::DataW-1:0]  w_elem_i,
  input  wire logic signed [fdaxpy_pkg::DataW-1:0]  z_in_i,
  input  wire logic signed [fdaxpy_pkg::DataW-1:0]  y_in0_i,
  input  wire logic signed [fdaxpy_pkg::DataW-1:0]  y_in1_i,
  input  wire logic signed [fdaxpy_pkg::DataW-1:0]  y_in2_i,
  input  wire logic signed [fdaxpy_pkg::DataW-1:0]  y_in3_i,
  input  wire logic                                 last_row_i,

  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed [fdaxpy_pkg::DataW-1:0]       z_out_o,
  output logic signed [fdaxpy_pkg::DataW-1:0]       y_out0_o,
  output logic signed [fdaxpy_pkg::DataW-1:0]       y_out1_o,
  output logic signed [fdaxpy_pkg::DataW-1:0]       y_out2_o,
  output logic signed [fdaxpy_pkg::DataW-1:0]       y_out3_o,
  output logic                                      y_valid_o
);

  localparam int DataW   = fdaxpy_pkg::DataW;
  localparam int AccW    = fdaxpy_pkg::AccW;
  localparam int MulW    = fdaxpy_pkg::MulW;
  localparam int ProdW   = fdaxpy_pkg::ProdW;
  localparam int WideW   = fdaxpy_pkg::WideW;
  localparam int NumCols = fdaxpy_pkg::NumCols;
  localparam int ColIdxW = fdaxpy_pkg::ColIdxW;
  localparam int Frac    = fdaxpy_pkg::FracBits;
  localparam logic [ColIdxW-1:0] LastCol = ColIdxW'(NumCols - 1);
  localparam logic [WideW:0]     Half    = (WideW+1)'(1) << (Frac - 1);

  fdaxpy_pkg::state_e state_q, state_d;

  logic [DataW-1:0] alpha_q, beta_q;
  logic [DataW-1:0] x_q [NumCols];

  logic [ColIdxW-1:0] j_q, j_d;
  logic [AccW-1:0]    rho_q [NumCols];
  logic [AccW-1:0]    rho_d [NumCols];

  logic [DataW-1:0] a_q [NumCols];
  logic [DataW-1:0] y_q [NumCols];
  logic [DataW-1:0] w_q;
  logic             last_q;
  logic             ld_in;

  logic [ProdW-1:0] prod_q, prod_d;
  logic [DataW-1:0] chi_q, chi_d;
  logic [AccW-1:0]  zacc_q, zacc_d;
  logic [WideW-1:0] wide_q, wide_d;
  logic [AccW-1:0]  tacc_q, tacc_d;
  logic [DataW-1:0] z_res_q, z_res_d;
  logic [DataW-1:0] y_res_q [NumCols];
  logic [DataW-1:0] y_res_d [NumCols];

  logic signed [MulW-1:0]  mul_a, mul_b;
  logic signed [ProdW-1:0] mul_p;

  logic [WideW-1:0] rnd_in;
  logic             rnd_w64;
  logic             rnd_neg;
  logic [WideW-1:0] rnd_mag;
  logic [WideW:0]   rnd_sum, rnd_shr, rnd_lim, rnd_sat;
  logic [AccW-1:0]  rnd_out;

  logic             out_valid_q, out_valid_d;
  logic             ld_out;
  logic [DataW-1:0] z_out_q;
  logic [DataW-1:0] y_out_q [NumCols];
  logic             y_valid_q;
  logic [AccW-1:0]  z_ext;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != fdaxpy_pkg::ST_IDLE);

  // shared multiplier
  assign mul_p = mul_a * mul_b;

  // shared rounder: round to nearest, ties away from zero, saturate to 32 or 64 bits
  always_comb begin
    rnd_neg = rnd_in[WideW-1];
    rnd_mag = rnd_neg ? (~rnd_in + WideW'(1)) : rnd_in;
    rnd_sum = {1'b0, rnd_mag} + Half;
    rnd_shr = rnd_sum >> Frac;
    rnd_lim = rnd_w64 ? ((WideW+1)'(1) << (AccW - 1)) : ((WideW+1)'(1) << (DataW - 1));
    if (!rnd_neg) begin
      rnd_lim = rnd_lim - (WideW+1)'(1);
    end
    rnd_sat = (rnd_shr > rnd_lim) ? rnd_lim : rnd_shr;
    rnd_out = rnd_neg ? (~rnd_sat[AccW-1:0] + AccW'(1)) : rnd_sat[AccW-1:0];
  end

  assign z_ext = {{(AccW-DataW){z_in_i[DataW-1]}}, z_in_i} <<< Frac;

  always_comb begin
    state_d     = state_q;
    j_d         = j_q;
    prod_d      = prod_q;
    chi_d       = chi_q;
    zacc_d      = zacc_q;
    wide_d      = wide_q;
    tacc_d      = tacc_q;
    z_res_d     = z_res_q;
    y_res_d     = y_res_q;
    rho_d       = rho_q;
    ld_in       = 1'b0;
    ld_out      = 1'b0;
    mul_a       = {alpha_q[DataW-1], alpha_q};
    mul_b       = {x_q[j_q][DataW-1], x_q[j_q]};
    rnd_in      = {{(WideW-ProdW){prod_q[ProdW-1]}}, prod_q};
    rnd_w64     = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      fdaxpy_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          ld_in   = 1'b1;
          j_d     = '0;
          zacc_d  = z_ext;
          for (int k = 0; k < NumCols; k++) begin
            y_res_d[k] = '0;
          end
          state_d = fdaxpy_pkg::ST_CHI_MUL;
        end
      end
      fdaxpy_pkg::ST_CHI_MUL: begin
        prod_d  = mul_p;
        state_d = fdaxpy_pkg::ST_CHI_RND;
      end
      fdaxpy_pkg::ST_CHI_RND: begin
        chi_d   = rnd_out[DataW-1:0];
        state_d = fdaxpy_pkg::ST_Z_MUL;
      end
      fdaxpy_pkg::ST_Z_MUL: begin
        mul_a   = {chi_q[DataW-1], chi_q};
        mul_b   = {a_q[j_q][DataW-1], a_q[j_q]};
        prod_d  = mul_p;
        state_d = fdaxpy_pkg::ST_Z_ADD;
      end
      fdaxpy_pkg::ST_Z_ADD: begin
        zacc_d  = fdaxpy_pkg::sat_add64(zacc_q, prod_q[AccW-1:0]);
        state_d = fdaxpy_pkg::ST_W_MUL;
      end
      fdaxpy_pkg::ST_W_MUL: begin
        mul_a   = {a_q[j_q][DataW-1], a_q[j_q]};
        mul_b   = {w_q[DataW-1], w_q};
        prod_d  = mul_p;
        state_d = fdaxpy_pkg::ST_W_ADD;
      end
      fdaxpy_pkg::ST_W_ADD: begin
        rho_d[j_q] = fdaxpy_pkg::sat_add64(rho_q[j_q], prod_q[AccW-1:0]);
        if (j_q == LastCol) begin
          j_d     = '0;
          state_d = fdaxpy_pkg::ST_Z_RND;
        end else begin
          j_d     = j_q + ColIdxW'(1);
          state_d = fdaxpy_pkg::ST_CHI_MUL;
        end
      end
      fdaxpy_pkg::ST_Z_RND: begin
        rnd_in  = {{(WideW-AccW){zacc_q[AccW-1]}}, zacc_q};
        z_res_d = rnd_out[DataW-1:0];
        state_d = last_q ? fdaxpy_pkg::ST_Y_LO : fdaxpy_pkg::ST_DONE;
      end
      fdaxpy_pkg::ST_Y_LO: begin
        mul_b   = {1'b0, rho_q[j_q][DataW-1:0]};
        prod_d  = mul_p;
        state_d = fdaxpy_pkg::ST_Y_HI;
      end
      fdaxpy_pkg::ST_Y_HI: begin
        wide_d  = {{(WideW-ProdW){prod_q[ProdW-1]}}, prod_q};
        mul_b   = {rho_q[j_q][AccW-1], rho_q[j_q][AccW-1:DataW]};
        prod_d  = mul_p;
        state_d = fdaxpy_pkg::ST_Y_CMB;
      end
      fdaxpy_pkg::ST_Y_CMB: begin
        wide_d  = wide_q + {prod_q[WideW-DataW-1:0], {DataW{1'b0}}};
        state_d = fdaxpy_pkg::ST_Y_RND;
      end
      fdaxpy_pkg::ST_Y_RND: begin
        rnd_in  = wide_q;
        rnd_w64 = 1'b1;
        tacc_d  = rnd_out;
        state_d = fdaxpy_pkg::ST_Y_MUL;
      end
      fdaxpy_pkg::ST_Y_MUL: begin
        mul_a   = {beta_q[DataW-1], beta_q};
        mul_b   = {y_q[j_q][DataW-1], y_q[j_q]};
        prod_d  = mul_p;
        state_d = fdaxpy_pkg::ST_Y_ADD;
      end
      fdaxpy_pkg::ST_Y_ADD: begin
        tacc_d  = fdaxpy_pkg::sat_add64(prod_q[AccW-1:0], tacc_q);
        state_d = fdaxpy_pkg::ST_Y_FIN;
      end
      fdaxpy_pkg::ST_Y_FIN: begin
        rnd_in       = {{(WideW-AccW){tacc_q[AccW-1]}}, tacc_q};
        y_res_d[j_q] = rnd_out[DataW-1:0];
        rho_d[j_q]   = '0;
        if (j_q == LastCol) begin
          j_d     = '0;
          state_d = fdaxpy_pkg::ST_DONE;
        end else begin
          j_d     = j_q + ColIdxW'(1);
          state_d = fdaxpy_pkg::ST_Y_LO;
        end
      end
      fdaxpy_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          ld_out      = 1'b1;
          out_valid_d = 1'b1;
          state_d     = fdaxpy_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fdaxpy_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fdaxpy_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q         <= '0;
      out_valid_q <= 1'b0;
      alpha_q     <= fdaxpy_pkg::AlphaReset;
      beta_q      <= '0;
      for (int k = 0; k < NumCols; k++) begin
        x_q[k]   <= '0;
        rho_q[k] <= '0;
      end
    end else begin
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
      rho_q       <= rho_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          fdaxpy_pkg::CFG_ALPHA:   alpha_q <= cfg_data_i;
          fdaxpy_pkg::CFG_BETA:    beta_q  <= cfg_data_i;
          fdaxpy_pkg::CFG_X_ZERO:  x_q[0]  <= cfg_data_i;
          fdaxpy_pkg::CFG_X_ONE:   x_q[1]  <= cfg_data_i;
          fdaxpy_pkg::CFG_X_TWO:   x_q[2]  <= cfg_data_i;
          fdaxpy_pkg::CFG_X_THREE: x_q[3]  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    chi_q   <= chi_d;
    zacc_q  <= zacc_d;
    wide_q  <= wide_d;
    tacc_q  <= tacc_d;
    z_res_q <= z_res_d;
    y_res_q <= y_res_d;
    if (ld_in) begin
      a_q[0] <= a_col0_i;
      a_q[1] <= a_col1_i;
      a_q[2] <= a_col2_i;
      a_q[3] <= a_col3_i;
      y_q[0] <= y_in0_i;
      y_q[1] <= y_in1_i;
      y_q[2] <= y_in2_i;
      y_q[3] <= y_in3_i;
      w_q    <= w_elem_i;
      last_q <= last_row_i;
    end
    if (ld_out) begin
      z_out_q   <= z_res_q;
      y_out_q   <= y_res_q;
      y_valid_q <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign z_out_o     = z_out_q;
  assign y_out0_o    = y_out_q[0];
  assign y_out1_o    = y_out_q[1];
  assign y_out2_o    = y_out_q[2];
  assign y_out3_o    = y_out_q[3];
  assign y_valid_o   = y_valid_q;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Frac    = fdaxpy_pkg::FracBits;
  localparam int DataW   = fdaxpy_pkg::DataW;
  localparam int NumCols = fdaxpy_pkg::NumCols;
  localparam int CfgIdxW = fdaxpy_pkg::CfgIdxW;
  localparam int DrainCycles = 80;
  localparam int StallLimit = 5000;

  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;

  localparam logic [DataW-1:0] QMax  = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] QMin  = 32'h8000_0000;
  localparam logic [DataW-1:0] QOne  = 32'h0001_0000;
  localparam logic [DataW-1:0] QHalf = 32'h0000_8000;

  typedef struct packed {
    logic [NumCols-1:0][DataW-1:0] a;
    logic [DataW-1:0]              w;
    logic [DataW-1:0]              z;
    logic [NumCols-1:0][DataW-1:0] y;
    logic                          last;
  } row_t;

  typedef struct packed {
    logic [DataW-1:0]              z;
    logic [NumCols-1:0][DataW-1:0] y;
    logic                          yv;
  } result_t;

  typedef enum int {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

  logic clk;
  logic rst_n;

  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [DataW-1:0]   cfg_data;

  logic in_valid;
  logic in_stall;
  row_t row_drv;

  logic                         out_valid;
  logic                         out_stall;
  wire [DataW-1:0]              z_out;
  wire [NumCols-1:0][DataW-1:0] y_out;
  wire                          y_valid;

  // predictor state
  longint alpha_q;
  longint beta_q;
  longint x_q [NumCols];
  longint rho_q [NumCols];

  result_t pending_results[$];
  int      mismatches;
  int      hold_request;
  int      burst_left;
  bit      gaps_on;

  fused_dot_axpy_four_column dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .a_col0_i    (row_drv.a[0]),
    .a_col1_i    (row_drv.a[1]),
    .a_col2_i    (row_drv.a[2]),
    .a_col3_i    (row_drv.a[3]),
    .w_elem_i    (row_drv.w),
    .z_in_i      (row_drv.z),
    .y_in0_i     (row_drv.y[0]),
    .y_in1_i     (row_drv.y[1]),
    .y_in2_i     (row_drv.y[2]),
    .y_in3_i     (row_drv.y[3]),
    .last_row_i  (row_drv.last),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .z_out_o     (z_out),
    .y_out0_o    (y_out[0]),
    .y_out1_o    (y_out[1]),
    .y_out2_o    (y_out[2]),
    .y_out3_o    (y_out[3]),
    .y_valid_o   (y_valid)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint sat_sum64(input longint p, input longint q);
    longint r;
    r = p + q;
    if (p[63] == q[63] && r[63] != p[63]) begin
      return p[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end
    return r;
  endfunction

  // round(m * n / 2^Frac), ties away from zero, saturated to width bits
  function automatic longint q_round_mul(input longint m, input longint n, input int width);
    logic [63:0]  mm;
    logic [63:0]  mn;
    logic [63:0]  hi;
    logic [63:0]  lo;
    logic [63:0]  limp;
    logic [63:0]  limn;
    logic [127:0] p;
    bit           neg;
    neg = (m < 0) != (n < 0);
    mm = (m < 0) ? -m : m;
    mn = (n < 0) ? -n : n;
    p = {64'd0, mm} * {64'd0, mn};
    p = (p + (128'd1 << (Frac - 1))) >> Frac;
    hi = p[127:64];
    lo = p[63:0];
    limp = (width >= 64) ? 64'h7FFF_FFFF_FFFF_FFFF : (64'd1 << (width - 1)) - 64'd1;
    limn = limp + 64'd1;
    if (neg) begin
      if (hi != 0 || lo > limn) lo = limn;
      return -lo;
    end
    if (hi != 0 || lo > limp) lo = limp;
    return lo;
  endfunction

  function automatic void set_coeff(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] val);
    longint v;
    v = longint'($signed(val));
    case (idx)
      fdaxpy_pkg::CFG_ALPHA:   alpha_q = v;
      fdaxpy_pkg::CFG_BETA:    beta_q = v;
      fdaxpy_pkg::CFG_X_ZERO:  x_q[0] = v;
      fdaxpy_pkg::CFG_X_ONE:   x_q[1] = v;
      fdaxpy_pkg::CFG_X_TWO:   x_q[2] = v;
      fdaxpy_pkg::CFG_X_THREE: x_q[3] = v;
      default: ;
    endcase
  endfunction

  function automatic result_t compute_row_result(input row_t r);
    result_t res;
    longint  zacc;
    longint  chi;
    longint  av;
    longint  t;
    zacc = longint'($signed(r.z)) * (longint'(1) << Frac);
    for (int j = 0; j < NumCols; j++) begin
      chi = q_round_mul(alpha_q, x_q[j], 32);
      av = longint'($signed(r.a[j]));
      zacc = sat_sum64(zacc, chi * av);
      rho_q[j] = sat_sum64(rho_q[j], av * longint'($signed(r.w)));
    end
    res.z = DataW'(q_round_mul(1, zacc, 32));
    for (int j = 0; j < NumCols; j++) begin
      res.y[j] = '0;
      if (r.last) begin
        t = sat_sum64(beta_q * longint'($signed(r.y[j])), q_round_mul(alpha_q, rho_q[j], 64));
        res.y[j] = DataW'(q_round_mul(1, t, 32));
        rho_q[j] = 0;
      end
    end
    res.yv = r.last;
    return res;
  endfunction

  always @(posedge clk) begin : scoreboard
    result_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) set_coeff(cfg_index, cfg_data);
      if (in_valid && !in_stall) pending_results.push_back(compute_row_result(row_drv));
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (z_out !== want.z) begin
            $error("z_out mismatch: expected %0d, got %0d", $signed(want.z), $signed(z_out));
            mismatches++;
          end
          for (int j = 0; j < NumCols; j++) begin
            if (y_out[j] !== want.y[j]) begin
              $error("y_out%0d mismatch: expected %0d, got %0d", j, $signed(want.y[j]),
                     $signed(y_out[j]));
              mismatches++;
            end
          end
          if (y_valid !== want.yv) begin
            $error("y_valid mismatch: expected %0d, got %0d", want.yv, y_valid);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin : receiver
    int       left;
    int       span;
    rx_mode_e mode;
    out_stall = 1'b0;
    left = 0;
    span = 0;
    mode = RX_FLOW;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        left = hold_request;
        hold_request = 0;
      end
      if (span == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        span = $urandom_range(64, 512);
      end
      span--;
      if (left > 0) begin
        left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          RX_FLOW:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:  out_stall <= ((span % 5) < 2);
        endcase
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [DataW-1:0] rand_extreme();
    case ($urandom_range(0, 4))
      0:       return QMin;
      1:       return QMax;
      2:       return '0;
      3:       return '1;
      default: return QOne;
    endcase
  endfunction

  // roughly +/-16.0
  function automatic logic [DataW-1:0] rand_small();
    return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
  endfunction

  function automatic logic [DataW-1:0] rand_q();
    case ($urandom_range(0, 9))
      0:       return rand_extreme();
      1, 2:    return $urandom();
      default: return rand_small();
    endcase
  endfunction

  function automatic row_t build_row(
    input logic [DataW-1:0] a0, input logic [DataW-1:0] a1,
    input logic [DataW-1:0] a2, input logic [DataW-1:0] a3,
    input logic [DataW-1:0] w, input logic [DataW-1:0] z,
    input logic [DataW-1:0] y0, input logic [DataW-1:0] y1,
    input logic [DataW-1:0] y2, input logic [DataW-1:0] y3,
    input logic last);
    row_t r;
    r.a = {a3, a2, a1, a0};
    r.w = w;
    r.z = z;
    r.y = {y3, y2, y1, y0};
    r.last = last;
    return r;
  endfunction

  function automatic row_t make_rand_row(input logic last);
    return build_row(rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q(),
                     rand_q(), rand_q(), rand_q(), rand_q(), last);
  endfunction

  task automatic offer_row(input row_t r);
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    row_drv <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic finish_rows();
    in_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_coeffs(
    input logic [DataW-1:0] alpha, input logic [DataW-1:0] beta,
    input logic [DataW-1:0] x0, input logic [DataW-1:0] x1,
    input logic [DataW-1:0] x2, input logic [DataW-1:0] x3);
    write_reg(fdaxpy_pkg::CFG_ALPHA, alpha);
    write_reg(fdaxpy_pkg::CFG_BETA, beta);
    write_reg(fdaxpy_pkg::CFG_X_ZERO, x0);
    write_reg(fdaxpy_pkg::CFG_X_ONE, x1);
    write_reg(fdaxpy_pkg::CFG_X_TWO, x2);
    write_reg(fdaxpy_pkg::CFG_X_THREE, x3);
  endtask

  task automatic test_directed_rows();
    gaps_on = 1'b0;
    // reset coefficients: z passes through, y = alpha * rho
    offer_row(build_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    offer_row(build_row(QMax, QMax, QMax, QMax, QMax, QMax, QMin, QMin, QMin, QMin, 1'b1));
    finish_rows();
    wait_idle();

    // half-LSB products round away from zero
    program_coeffs(QOne, QHalf, QHalf, 32'hFFFF_0000, 32'h0002_8000, 32'hFFFF_C000);
    offer_row(build_row(32'd1, 0, 0, 0, QOne, 0, 0, 0, 0, 0, 1'b0));
    offer_row(build_row(32'hFFFF_FFFF, 0, 0, 0, QOne, 0, 0, 0, 0, 0, 1'b0));
    offer_row(build_row(32'h0003_0000, 32'h0001_8000, 32'hFFFE_0000, 32'h0000_4000,
                        32'h0002_0000, 32'h0010_0000, QOne, 32'hFFFF_0000,
                        32'h0005_0000, 0, 1'b1));
    finish_rows();
    wait_idle();

    // chi and z saturate both ways, accumulators saturate, then clear
    program_coeffs(QMax, QMin, QMax, QMin, QMax, QMin);
    offer_row(build_row(QMax, QMin, QMax, QMin, QMax, QMax, 0, 0, 0, 0, 1'b0));
    offer_row(build_row(QMin, QMax, QMin, QMax, QMin, QMin, 0, 0, 0, 0, 1'b0));
    offer_row(build_row(QMin, QMin, QMin, QMin, QMin, 0, QMax, QMin, QMax, QMin, 1'b0));
    offer_row(build_row(QMin, QMin, QMin, QMin, QMin, 0, QMax, QMin, QMax, QMin, 1'b1));
    offer_row(build_row(0, 0, 0, 0, 0, 0, QMax, QMax, QMax, QMax, 1'b0));
    offer_row(build_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    finish_rows();
    wait_idle();

    program_coeffs(QMin, QMax, QMin, QMax, 0, 32'hFFFF_FFFF);
    offer_row(build_row(QOne, QOne, QMax, QMin, QHalf, 32'hFFF0_0000, 0, 0, 0, 0, 1'b0));
    offer_row(build_row(QMin, 32'hFFFF_FFFF, 32'd1, QMax, QMax, QMin, 0, 0, 0, 0, 1'b0));
    offer_row(build_row(32'h0000_8000, QOne, QMin, QMax, 32'hFFFF_8000, 0,
                        QMax, QMin, 32'hFFFF_FFFF, 32'd1, 1'b1));
    finish_rows();
    wait_idle();
  endtask

  task automatic test_unused_index();
    gaps_on = 1'b1;
    burst_left = 0;
    write_reg(CFG_SPARE_LO, $urandom());
    write_reg(CFG_SPARE_HI, $urandom());
    for (int k = 0; k < 4; k++) offer_row(make_rand_row(k == 3));
    finish_rows();
    wait_idle();
  endtask

  task automatic test_random_settings();
    int rows;
    int len;
    int sel;
    bit broken;
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: program_coeffs(rand_small(), rand_small(), rand_small(), rand_small(),
                          rand_small(), rand_small());
        1: program_coeffs(rand_q(), rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
        2: program_coeffs(QOne, 0, rand_small(), rand_small(), rand_small(), rand_small());
        3: program_coeffs(rand_extreme(), rand_extreme(), rand_extreme(), rand_extreme(),
                          rand_extreme(), rand_extreme());
        4: program_coeffs(0, rand_small(), rand_q(), rand_q(), rand_q(), rand_q());
        5: program_coeffs($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                          $urandom());
        default: program_coeffs(rand_small(), rand_q(), rand_small(), rand_small(),
                                rand_small(), rand_small());
      endcase
      gaps_on = (phase % 3 != 2);
      burst_left = 0;
      rows = 0;
      while (rows < 240) begin
        sel = $urandom_range(0, 19);
        broken = (sel == 0);
        len = (sel < 16) ? $urandom_range(1, 8) : $urandom_range(9, 40);
        for (int k = 0; k < len; k++) begin
          offer_row(make_rand_row(broken ? ($urandom_range(0, 3) == 0) : (k == len - 1)));
          rows++;
        end
      end
      finish_rows();
      wait_idle();
    end
  endtask

  task automatic test_input_backpressure();
    gaps_on = 1'b0;
    program_coeffs(rand_small(), rand_small(), rand_small(), rand_small(),
                   rand_small(), rand_small());
    hold_request = 400;
    for (int k = 0; k < 40; k++) offer_row(make_rand_row((k % 5) == 4));
    finish_rows();
    wait_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    row_drv = '0;
    mismatches = 0;
    hold_request = 0;
    burst_left = 0;
    gaps_on = 1'b0;
    alpha_q = longint'(1) << Frac;
    beta_q = 0;
    for (int j = 0; j < NumCols; j++) begin
      x_q[j] = 0;
      rho_q[j] = 0;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_rows();
    test_unused_index();
    test_random_settings();
    test_input_backpressure();

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
